// File: hdl/assert_macros.svh
// Assertion helpers shared by the receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define FPR_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/fpr_pkg.sv
package fpr_pkg;

    localparam int CMDQ_DEPTH_DEF = 4;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMISCUOUS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_ACK_MASK = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED    = 8'd3;

    localparam logic [7:0]  START_BYTE = 8'h02;
    localparam logic [7:0]  END_BYTE   = 8'h03;
    localparam logic [7:0]  ACK_CODE   = 8'h06;
    localparam logic [7:0]  NAK_CODE   = 8'h15;
    localparam logic [23:0] BCAST_ADDR = 24'hFFFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [1:0] VERD_DELIVERED  = 2'd0;
    localparam logic [1:0] VERD_SUPPRESSED = 2'd1;
    localparam logic [1:0] VERD_BAD_END    = 2'd2;
    localparam logic [1:0] VERD_BAD_CRC    = 2'd3;

    localparam int SUB_W = 3;
    localparam logic [SUB_W-1:0] SUB_CODE    = 3'd0;
    localparam logic [SUB_W-1:0] SUB_SEQ     = 3'd1;
    localparam logic [SUB_W-1:0] SUB_NSEQ    = 3'd2;
    localparam logic [SUB_W-1:0] SUB_TYPE    = 3'd3;
    localparam logic [SUB_W-1:0] SUB_VERDICT = 3'd4;

    typedef struct packed {
        logic [23:0] own_address;
        logic        promiscuous_mode;
        logic [7:0]  no_ack_mask;
        logic [15:0] crc_seed;
    } t_cfg;

    typedef struct packed {
        logic        is_end;
        logic [7:0]  data;
        logic [7:0]  index;
        logic        reply;
        logic [1:0]  verdict;
        logic [7:0]  seq;
        logic [7:0]  ftype;
        logic [23:0] dest;
        logic [7:0]  length;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [7:0]  index;
        logic        last;
        logic [1:0]  verdict;
        logic [7:0]  seq;
        logic [7:0]  ftype;
        logic [23:0] dest;
        logic [7:0]  length;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: hdl/framed_packet_receiver.sv
// Framed packet receiver: hunts for start byte 0x02 in a received byte stream,
// parses the header, passes payload bytes on with their index, checks the
// CRC-16 and end byte, and reports ACK/NAK reply bytes and a frame verdict.
// Input channel: drive i_rx_byte with push high; a byte is taken at a clock
// edge where push is high and full is low; one byte per cycle until full rises.
// Result channel: while empty is low the oldest result sits on the o_ ports;
// pop high at a clock edge takes it. The first result of a byte enters the
// request queue at the edge that takes the byte and reaches the ports when the
// result register loads it. A payload byte gives one result, an end byte one or
// five (four reply bytes, then verdict), delivered one per cycle while popped.
// A four-entry request queue sits between parser and result stage; full rises
// when it fills, so a receiver that stops popping stalls input after at most
// four pending requests plus the result register.
// Config channel: i_cfg_valid with i_cfg_index/i_cfg_data, taken when
// o_cfg_ready is high (always). Write only while no frame is in progress.
// Reset (synchronous, active low) returns to start-byte hunt, empties the queue
// and clears state and config registers, last good sequence and CRC seed to 0.
module framed_packet_receiver #(
    parameter int CMDQ_DEPTH = fpr_pkg::CMDQ_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     o_out_kind,
    output logic [7:0]                     o_out_byte,
    output logic [7:0]                     o_byte_index,
    output logic                           o_last,
    output logic [1:0]                     o_verdict,
    output logic [7:0]                     o_seq_out,
    output logic [7:0]                     o_frame_type,
    output logic [23:0]                    o_dest_address,
    output logic [7:0]                     o_payload_length,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fpr_pkg::t_cfg     r_cfg;
    fpr_pkg::t_cmd     w_front_cmd;
    fpr_pkg::t_cmd     w_head_cmd;
    fpr_pkg::t_result  w_result;
    logic              w_accept;
    logic              w_cmd_wr;
    logic              w_cmd_valid;
    logic              w_cmd_rd;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpr_pkg::CFG_OWN_ADDRESS: r_cfg.own_address      <= i_cfg_data[23:0];
                fpr_pkg::CFG_PROMISCUOUS: r_cfg.promiscuous_mode <= i_cfg_data[0];
                fpr_pkg::CFG_NO_ACK_MASK: r_cfg.no_ack_mask      <= i_cfg_data[7:0];
                fpr_pkg::CFG_CRC_SEED:    r_cfg.crc_seed         <= i_cfg_data[15:0];
                default:                  r_cfg                  <= r_cfg;
            endcase
        end
    end

    fpr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_cmd_wr  (w_cmd_wr),
        .o_cmd     (w_front_cmd)
    );

    fpr_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_wr),
        .i_wdata (w_front_cmd),
        .o_full  (full),
        .o_valid (w_cmd_valid),
        .i_rd    (w_cmd_rd),
        .o_rdata (w_head_cmd)
    );

    fpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_rd    (w_cmd_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (w_result)
    );

    assign o_out_kind       = w_result.kind;
    assign o_out_byte       = w_result.data;
    assign o_byte_index     = w_result.index;
    assign o_last           = w_result.last;
    assign o_verdict        = w_result.verdict;
    assign o_seq_out        = w_result.seq;
    assign o_frame_type     = w_result.ftype;
    assign o_dest_address   = w_result.dest;
    assign o_payload_length = w_result.length;

endmodule

// File: hdl/fpr_front.sv
`include "assert_macros.svh"

module fpr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fpr_pkg::t_cfg  i_cfg,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    output logic           o_cmd_wr,
    output fpr_pkg::t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        PH_HUNT = 12'b0000_0000_0001,
        PH_SEQ  = 12'b0000_0000_0010,
        PH_TYPE = 12'b0000_0000_0100,
        PH_D1   = 12'b0000_0000_1000,
        PH_D2   = 12'b0000_0001_0000,
        PH_D3   = 12'b0000_0010_0000,
        PH_LEN  = 12'b0000_0100_0000,
        PH_NLEN = 12'b0000_1000_0000,
        PH_PAY  = 12'b0001_0000_0000,
        PH_CRC1 = 12'b0010_0000_0000,
        PH_CRC2 = 12'b0100_0000_0000,
        PH_END  = 12'b1000_0000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_type, n_type;
    logic [23:0] r_dest, n_dest;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rxcrc, n_rxcrc;
    logic [7:0]  r_last_good, n_last_good;

    logic [7:0]  w_cnt_inc;
    logic [15:0] w_crc_upd;
    logic        w_ours;
    logic        w_reply;
    logic        w_dup;
    logic        w_addr_ok;

    assign w_cnt_inc = r_cnt + 8'd1;
    assign w_crc_upd = fpr_pkg::crc_byte(r_crc, i_rx_byte);
    assign w_ours    = (r_dest == i_cfg.own_address);
    assign w_reply   = w_ours && ((r_type & i_cfg.no_ack_mask) == 8'd0);
    assign w_dup     = (r_last_good == r_seq) && w_ours;
    assign w_addr_ok = (r_dest == fpr_pkg::BCAST_ADDR) || w_ours;

    always_comb begin
        n_phase     = r_phase;
        n_seq       = r_seq;
        n_type      = r_type;
        n_dest      = r_dest;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_rxcrc     = r_rxcrc;
        n_last_good = r_last_good;
        o_cmd_wr    = 1'b0;
        o_cmd       = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == fpr_pkg::START_BYTE) begin
                        n_crc   = fpr_pkg::crc_byte(i_cfg.crc_seed, i_rx_byte);
                        n_phase = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    n_seq   = i_rx_byte;
                    n_crc   = w_crc_upd;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_crc   = w_crc_upd;
                    n_phase = PH_D1;
                end
                PH_D1: begin
                    n_dest  = {i_rx_byte, 16'h0000};
                    n_crc   = w_crc_upd;
                    n_phase = PH_D2;
                end
                PH_D2: begin
                    n_dest  = {r_dest[23:16], i_rx_byte, 8'h00};
                    n_crc   = w_crc_upd;
                    n_phase = PH_D3;
                end
                PH_D3: begin
                    n_dest  = {r_dest[23:8], i_rx_byte};
                    n_crc   = w_crc_upd;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_crc   = w_crc_upd;
                    n_phase = PH_NLEN;
                end
                PH_NLEN: begin
                    if (~i_rx_byte != r_len) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_crc   = w_crc_upd;
                        n_cnt   = 8'd0;
                        n_phase = (r_len != 8'd0) ? PH_PAY : PH_CRC1;
                    end
                end
                PH_PAY: begin
                    n_crc       = w_crc_upd;
                    o_cmd_wr    = 1'b1;
                    o_cmd.data  = i_rx_byte;
                    o_cmd.index = r_cnt;
                    n_cnt       = w_cnt_inc;
                    if (w_cnt_inc == r_len) begin
                        n_phase = PH_CRC1;
                    end
                end
                PH_CRC1: begin
                    n_rxcrc = {i_rx_byte, 8'h00};
                    n_phase = PH_CRC2;
                end
                PH_CRC2: begin
                    n_rxcrc = {r_rxcrc[15:8], i_rx_byte};
                    n_phase = PH_END;
                end
                PH_END: begin
                    o_cmd_wr     = 1'b1;
                    o_cmd.is_end = 1'b1;
                    o_cmd.reply  = w_reply;
                    o_cmd.seq    = r_seq;
                    o_cmd.ftype  = r_type;
                    o_cmd.dest   = r_dest;
                    o_cmd.length = r_len;
                    priority if (i_rx_byte != fpr_pkg::END_BYTE) begin
                        o_cmd.verdict = fpr_pkg::VERD_BAD_END;
                        o_cmd.data    = fpr_pkg::NAK_CODE;
                    end else if (r_crc != r_rxcrc) begin
                        o_cmd.verdict = fpr_pkg::VERD_BAD_CRC;
                        o_cmd.data    = fpr_pkg::NAK_CODE;
                    end else begin
                        o_cmd.data    = fpr_pkg::ACK_CODE;
                        o_cmd.verdict = (i_cfg.promiscuous_mode || (!w_dup && w_addr_ok))
                                        ? fpr_pkg::VERD_DELIVERED
                                        : fpr_pkg::VERD_SUPPRESSED;
                        n_last_good   = r_seq;
                    end
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_seq       <= 8'd0;
            r_type      <= 8'd0;
            r_dest      <= 24'd0;
            r_len       <= 8'd0;
            r_cnt       <= 8'd0;
            r_crc       <= 16'd0;
            r_rxcrc     <= 16'd0;
            r_last_good <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_type      <= n_type;
            r_dest      <= n_dest;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_crc       <= n_crc;
            r_rxcrc     <= n_rxcrc;
            r_last_good <= n_last_good;
        end
    end

    `FPR_ASSERT(a_pay_index_in_range, i_clk, i_rst_n,
        (o_cmd_wr && !o_cmd.is_end) |-> (o_cmd.index < r_len), "payload index past length")
    `FPR_ASSERT(a_good_frame_seq, i_clk, i_rst_n,
        (o_cmd_wr && o_cmd.is_end && o_cmd.data == fpr_pkg::ACK_CODE) |=> (r_last_good == $past(r_seq)),
        "last good sequence not taken")

endmodule

// File: hdl/fpr_cmdq.sv
`include "assert_macros.svh"

module fpr_cmdq #(
    parameter int DEPTH = fpr_pkg::CMDQ_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  fpr_pkg::t_cmd  i_wdata,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_rd,
    output fpr_pkg::t_cmd  o_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fpr_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_do_wr, w_do_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_wr && !w_do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_rd && !w_do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `FPR_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_FULL, "queue count overflow")
    `FPR_NEVER(a_write_when_full, i_clk, i_rst_n, i_wr && o_full, "request written to full queue")

endmodule

// File: hdl/fpr_back.sv
`include "assert_macros.svh"

module fpr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  fpr_pkg::t_cmd     i_cmd,
    output logic              o_cmd_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output fpr_pkg::t_result  o_result
);

    logic                       r_valid;
    logic [fpr_pkg::SUB_W-1:0]  r_sub;
    fpr_pkg::t_result           r_item;
    fpr_pkg::t_result           w_item;
    logic                       w_load;
    logic                       w_final;

    assign w_load   = i_cmd_valid && (!r_valid || i_pop);
    assign o_cmd_rd = w_load && w_final;
    assign o_empty  = !r_valid;
    assign o_result = r_item;

    always_comb begin
        w_item  = '0;
        w_final = 1'b1;
        priority if (!i_cmd.is_end) begin
            w_item.kind  = fpr_pkg::KIND_PAYLOAD;
            w_item.data  = i_cmd.data;
            w_item.index = i_cmd.index;
            w_item.last  = 1'b1;
        end else if (i_cmd.reply && r_sub != fpr_pkg::SUB_VERDICT) begin
            w_item.kind = fpr_pkg::KIND_REPLY;
            w_final     = 1'b0;
            unique case (r_sub)
                fpr_pkg::SUB_CODE: w_item.data = i_cmd.data;
                fpr_pkg::SUB_SEQ:  w_item.data = i_cmd.seq;
                fpr_pkg::SUB_NSEQ: w_item.data = ~i_cmd.seq;
                fpr_pkg::SUB_TYPE: w_item.data = i_cmd.ftype;
                default:           w_item.data = i_cmd.data;
            endcase
        end else begin
            w_item.kind    = fpr_pkg::KIND_VERDICT;
            w_item.last    = 1'b1;
            w_item.verdict = i_cmd.verdict;
            w_item.seq     = i_cmd.seq;
            w_item.ftype   = i_cmd.ftype;
            w_item.dest    = i_cmd.dest;
            w_item.length  = i_cmd.length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= fpr_pkg::SUB_CODE;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_sub   <= w_final ? fpr_pkg::SUB_CODE : r_sub + 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    `FPR_NEVER(a_sub_bound, i_clk, i_rst_n, r_sub > fpr_pkg::SUB_VERDICT, "reply step out of range")
    `FPR_ASSERT(a_verdict_last, i_clk, i_rst_n,
        (r_valid && r_item.kind == fpr_pkg::KIND_VERDICT) |-> r_item.last,
        "verdict not marked last")

endmodule

// File: verif/rx_frame_sb_pkg.sv
`timescale 1ns / 100ps

package rx_frame_sb_pkg;

    import fpr_pkg::*;

    typedef enum logic [3:0] {
        RX_HUNT,
        RX_SEQ,
        RX_TYPE,
        RX_DEST_HI,
        RX_DEST_MID,
        RX_DEST_LO,
        RX_LEN,
        RX_NLEN,
        RX_PAYLOAD,
        RX_CRC_HI,
        RX_CRC_LO,
        RX_END
    } rx_state_e;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    class rx_frame_scoreboard;

        logic [23:0] own_addr;
        logic        promisc;
        logic [7:0]  ack_mask;
        logic [15:0] crc_seed;

        rx_state_e   state;
        logic [7:0]  seq_hold;
        logic [7:0]  type_hold;
        logic [23:0] dest_hold;
        logic [7:0]  len_hold;
        logic [7:0]  pay_count;
        logic [15:0] crc_run;
        logic [15:0] crc_rx;
        logic [7:0]  last_seq;

        t_result     frame_q[$];

        int unsigned errors;
        int unsigned rx_bytes;
        int unsigned n_payload;
        int unsigned n_reply;
        int unsigned n_verdict[4];

        function new();
            own_addr  = '0;
            promisc   = 1'b0;
            ack_mask  = '0;
            crc_seed  = '0;
            state     = RX_HUNT;
            seq_hold  = '0;
            type_hold = '0;
            dest_hold = '0;
            len_hold  = '0;
            pay_count = '0;
            crc_run   = '0;
            crc_rx    = '0;
            last_seq  = '0;
            errors    = 0;
            rx_bytes  = 0;
            n_payload = 0;
            n_reply   = 0;
            foreach (n_verdict[i]) n_verdict[i] = 0;
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OWN_ADDRESS: own_addr = val[23:0];
                CFG_PROMISCUOUS: promisc  = val[0];
                CFG_NO_ACK_MASK: ack_mask = val[7:0];
                CFG_CRC_SEED:    crc_seed = val[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return frame_q.size();
        endfunction

        // byte that walks an open frame back toward the start-byte hunt
        function logic [7:0] filler_byte();
            return (state == RX_NLEN) ? (~len_hold ^ 8'h01) : 8'h00;
        endfunction

        function t_result make_result(logic [1:0] kind, logic [7:0] data, logic [7:0] idx,
                                      logic [1:0] verd, bit hdr);
            t_result r;
            r = '0;
            r.kind    = kind;
            r.data    = data;
            r.index   = idx;
            r.verdict = verd;
            if (hdr) begin
                r.seq    = seq_hold;
                r.ftype  = type_hold;
                r.dest   = dest_hold;
                r.length = len_hold;
            end
            return r;
        endfunction

        function void note_rx_byte(logic [7:0] b);
            t_result     burst[$];
            logic        ours;
            logic        reply;
            logic [1:0]  verd;
            logic [7:0]  code;
            rx_bytes++;
            case (state)
                RX_HUNT: begin
                    if (b == START_BYTE) begin
                        crc_run = crc16_update(crc_seed, b);
                        state   = RX_SEQ;
                    end
                end
                RX_SEQ: begin
                    seq_hold = b;
                    crc_run  = crc16_update(crc_run, b);
                    state    = RX_TYPE;
                end
                RX_TYPE: begin
                    type_hold = b;
                    crc_run   = crc16_update(crc_run, b);
                    state     = RX_DEST_HI;
                end
                RX_DEST_HI: begin
                    dest_hold = {b, 16'h0000};
                    crc_run   = crc16_update(crc_run, b);
                    state     = RX_DEST_MID;
                end
                RX_DEST_MID: begin
                    dest_hold[15:8] = b;
                    crc_run         = crc16_update(crc_run, b);
                    state           = RX_DEST_LO;
                end
                RX_DEST_LO: begin
                    dest_hold[7:0] = b;
                    crc_run        = crc16_update(crc_run, b);
                    state          = RX_LEN;
                end
                RX_LEN: begin
                    len_hold = b;
                    crc_run  = crc16_update(crc_run, b);
                    state    = RX_NLEN;
                end
                RX_NLEN: begin
                    if (~b != len_hold) begin
                        state = RX_HUNT;
                    end else begin
                        crc_run   = crc16_update(crc_run, b);
                        pay_count = '0;
                        state     = (len_hold != 0) ? RX_PAYLOAD : RX_CRC_HI;
                    end
                end
                RX_PAYLOAD: begin
                    crc_run = crc16_update(crc_run, b);
                    burst.push_back(make_result(KIND_PAYLOAD, b, pay_count, VERD_DELIVERED, 0));
                    pay_count++;
                    if (pay_count == len_hold) state = RX_CRC_HI;
                end
                RX_CRC_HI: begin
                    crc_rx[15:8] = b;
                    state        = RX_CRC_LO;
                end
                RX_CRC_LO: begin
                    crc_rx[7:0] = b;
                    state       = RX_END;
                end
                RX_END: begin
                    ours  = (dest_hold == own_addr);
                    reply = ours && ((type_hold & ack_mask) == 0);
                    if (b != END_BYTE) begin
                        verd = VERD_BAD_END;
                        code = NAK_CODE;
                    end else if (crc_run != crc_rx) begin
                        verd = VERD_BAD_CRC;
                        code = NAK_CODE;
                    end else begin
                        code = ACK_CODE;
                        verd = (promisc || (!(last_seq == seq_hold && ours)
                                && (dest_hold == BCAST_ADDR || ours)))
                               ? VERD_DELIVERED : VERD_SUPPRESSED;
                        last_seq = seq_hold;
                    end
                    if (reply) begin
                        burst.push_back(make_result(KIND_REPLY, code, 8'd0, VERD_DELIVERED, 0));
                        burst.push_back(make_result(KIND_REPLY, seq_hold, 8'd0, VERD_DELIVERED, 0));
                        burst.push_back(make_result(KIND_REPLY, ~seq_hold, 8'd0, VERD_DELIVERED, 0));
                        burst.push_back(make_result(KIND_REPLY, type_hold, 8'd0, VERD_DELIVERED, 0));
                        n_reply += 4;
                    end
                    burst.push_back(make_result(KIND_VERDICT, 8'd0, 8'd0, verd, 1));
                    n_verdict[verd]++;
                    state = RX_HUNT;
                end
                default: state = RX_HUNT;
            endcase
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) begin
                if (burst[i].kind == KIND_PAYLOAD) n_payload++;
                frame_q.push_back(burst[i]);
            end
        endfunction

        function void compare(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want) begin
                errors++;
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (frame_q.size() == 0) begin
                errors++;
                $error("result with nothing expected: out_kind %0d out_byte %0h",
                       got.kind, got.data);
                return;
            end
            want = frame_q.pop_front();
            compare("out_kind", want.kind, got.kind);
            compare("out_byte", want.data, got.data);
            compare("byte_index", want.index, got.index);
            compare("last", want.last, got.last);
            compare("verdict", want.verdict, got.verdict);
            compare("seq_out", want.seq, got.seq);
            compare("frame_type", want.ftype, got.ftype);
            compare("dest_address", want.dest, got.dest);
            compare("payload_length", want.length, got.length);
        endfunction

    endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import fpr_pkg::*;
    import rx_frame_sb_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_BYTES  = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            i_rx_byte = 8'h00;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            o_out_kind;
    logic [7:0]            o_out_byte;
    logic [7:0]            o_byte_index;
    logic                  o_last;
    logic [1:0]            o_verdict;
    logic [7:0]            o_seq_out;
    logic [7:0]            o_frame_type;
    logic [23:0]           o_dest_address;
    logic [7:0]            o_payload_length;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rx_frame_scoreboard sb;
    t_result            seen;
    int unsigned        idle_cycles = 0;
    int unsigned        pop_cycle = 0;
    int unsigned        burst_left = 0;

    framed_packet_receiver u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: cycle through free-running, random, slow and alternating pop patterns
    always @(negedge i_clk) begin
        pop_cycle++;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            case ((pop_cycle / 200) % 4)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 3) != 0);
                2: pop <= ((pop_cycle % 32) < 6);
                default: pop <= ((pop_cycle % 2) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                seen = '{kind: o_out_kind, data: o_out_byte, index: o_byte_index,
                         last: o_last, verdict: o_verdict, seq: o_seq_out,
                         ftype: o_frame_type, dest: o_dest_address,
                         length: o_payload_length};
                sb.check_result(seen);
            end
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        sb.note_rx_byte(b);
    endtask

    task automatic send_crc_byte(input logic [7:0] b, ref logic [15:0] crc);
        crc = crc16_update(crc, b);
        send_rx_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] seq, input logic [7:0] ftype,
                              input logic [23:0] dest, input logic [7:0] len,
                              input logic [15:0] crc_xor, input logic [7:0] end_byte,
                              input logic [7:0] nlen_xor);
        logic [15:0] crc;
        crc = sb.crc_seed;
        send_crc_byte(START_BYTE, crc);
        send_crc_byte(seq, crc);
        send_crc_byte(ftype, crc);
        send_crc_byte(dest[23:16], crc);
        send_crc_byte(dest[15:8], crc);
        send_crc_byte(dest[7:0], crc);
        send_crc_byte(len, crc);
        send_crc_byte(~len ^ nlen_xor, crc);
        if (nlen_xor == 8'd0) begin
            repeat (len) send_crc_byte(8'($urandom), crc);
            crc = crc ^ crc_xor;
            send_rx_byte(crc[15:8]);
            send_rx_byte(crc[7:0]);
            send_rx_byte(end_byte);
        end
    endtask

    task automatic random_frame();
        logic [23:0] dest;
        logic [7:0]  seq;
        logic [7:0]  len;
        logic [7:0]  end_byte;
        logic [7:0]  noise;
        logic [15:0] crc_xor;
        int          pick;
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0) begin
            noise = 8'($urandom);
            if (noise == START_BYTE && $urandom_range(0, 3) != 0) noise = ~noise;
            send_rx_byte(noise);
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) dest = sb.own_addr;
        else if (pick < 6) dest = BCAST_ADDR;
        else if (pick == 6) dest = sb.own_addr ^ (24'd1 << $urandom_range(0, 23));
        else dest = 24'($urandom);
        seq = ($urandom_range(0, 1) == 0) ? sb.last_seq : 8'($urandom);
        len = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 6)) : 8'($urandom_range(7, 40));
        crc_xor  = 16'd0;
        end_byte = END_BYTE;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            crc_xor = 16'd1 << $urandom_range(0, 15);
        end else if (pick < 4) begin
            end_byte = 8'($urandom);
            if (end_byte == END_BYTE) end_byte = ~end_byte;
        end
        send_frame(seq, 8'($urandom), dest, len, crc_xor, end_byte,
                   (pick == 4) ? 8'($urandom_range(1, 255)) : 8'd0);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_config(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [23:0] addr, input logic prom,
                                input logic [7:0] mask, input logic [15:0] seed);
        // close any frame left open so registers change between frames
        while (sb.state != RX_HUNT) send_rx_byte(sb.filler_byte());
        wait_drained();
        write_reg(CFG_OWN_ADDRESS, addr);
        write_reg(CFG_PROMISCUOUS, {23'd0, prom});
        write_reg(CFG_NO_ACK_MASK, {16'd0, mask});
        write_reg(CFG_CRC_SEED, {8'd0, seed});
    endtask

    initial begin
        int unsigned mark;
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_rx_byte(8'hFF);
        send_rx_byte(8'h00);
        send_frame(8'h00, 8'h00, 24'h000000, 8'd0, 16'd0, END_BYTE, 8'd0);
        send_frame(8'h01, 8'h00, 24'h000000, 8'd1, 16'd0, END_BYTE, 8'hFC);
        send_frame(8'hFF, 8'hFF, BCAST_ADDR, 8'd1, 16'd0, 8'h00, 8'd0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: apply_config(24'($urandom_range(1, 24'hFFFFFE)), 1'b0, 8'h00, 16'hFFFF);
                1: apply_config(BCAST_ADDR, 1'b0, 8'h80, 16'h1D0F);
                2: begin
                    apply_config(24'($urandom), 1'b1, 8'hFF, 16'($urandom));
                    write_reg(CFG_UNMAPPED, 24'($urandom));
                end
                3: apply_config(24'h000000, 1'b0, 8'($urandom), 16'h0000);
                default: apply_config(24'($urandom), 1'b1, 8'h00, 16'($urandom));
            endcase
            mark = sb.rx_bytes;
            if (p == 4) begin
                send_frame(8'($urandom), 8'h00, sb.own_addr, 8'hFF, 16'd0, END_BYTE, 8'd0);
            end
            while (sb.rx_bytes - mark < PHASE_BYTES) random_frame();
        end

        wait_drained();
        $display("Sent %0d bytes over 6 register settings; got %0d payload and %0d reply results",
                 sb.rx_bytes, sb.n_payload, sb.n_reply);
        $display("Frame verdicts delivered/suppressed/bad end/bad CRC: %0d/%0d/%0d/%0d",
                 sb.n_verdict[VERD_DELIVERED], sb.n_verdict[VERD_SUPPRESSED],
                 sb.n_verdict[VERD_BAD_END], sb.n_verdict[VERD_BAD_CRC]);
        if (sb.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/fpr_pkg.sv
hdl/fpr_front.sv
hdl/fpr_cmdq.sv
hdl/fpr_back.sv
hdl/framed_packet_receiver.sv
verif/rx_frame_sb_pkg.sv
verif/tb_top.sv
